FILE: src/kdi_pkg.sv
// Package for the k-mer dedup indexer: widths, table geometry, FSM state type,
// controller/datapath command and status structs, and the hash multiplier.
// No dependencies.
package kdi_pkg;

  localparam int unsigned TableEntries = 65536;
  localparam int unsigned SlotW = $clog2(TableEntries);
  localparam int unsigned IdLimit = (TableEntries < 65536) ? TableEntries : 65536;
  localparam int unsigned IdCntW = $clog2(IdLimit + 1);
  localparam int unsigned ProbeCntW = $clog2(TableEntries + 1);

  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChHeader  = 8'h3E;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [5:0] KmerLenReset = 6'd31;
  localparam logic [31:0] U32Max = 32'hFFFF_FFFF;
  localparam logic [63:0] HashMul = 64'h9E37_79B9_7F4A_7C15;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } kdi_state_t;

  typedef struct packed {
    logic clear_slot;   // clear valid bit at clear counter
    logic take_byte;    // parse the input byte
    logic mul_step0;
    logic mul_step1;
    logic mul_step2;
    logic hash_fold;    // form the slot index
    logic mem_read;     // issue table read at probe index
    logic probe_next;   // advance probe index
    logic do_insert;    // write new entry
    logic set_hit;      // latch hit result
    logic set_full;     // latch full result
    logic emit;         // drive the result strobe
  } kdi_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic want_lookup;  // byte produced a k-mer
    logic slot_free;
    logic key_match;
    logic ids_exhausted;
    logic probes_done;
  } kdi_stat_t;

endpackage

FILE: src/kdi_ctrl.sv
// Controller FSM of the k-mer dedup indexer: clearing pass, parse,
// multi-cycle hash, linear probe loop. Depends on kdi_pkg.
module kdi_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  kdi_pkg::kdi_stat_t stat,
  output kdi_pkg::kdi_cmd_t cmd,
  output logic busy
);
  import kdi_pkg::*;

  kdi_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (stat.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (start && stat.want_lookup) state_next = ST_MUL0;
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_HASH;
      ST_HASH:  state_next = ST_READ;
      ST_READ:  state_next = ST_CMP;
      ST_CMP: begin
        if (stat.slot_free || stat.key_match || stat.probes_done) state_next = ST_EMIT;
        else state_next = ST_READ;
      end
      ST_EMIT:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR: cmd.clear_slot = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        cmd.take_byte = start;
      end
      ST_MUL0: cmd.mul_step0 = 1'b1;
      ST_MUL1: cmd.mul_step1 = 1'b1;
      ST_MUL2: cmd.mul_step2 = 1'b1;
      ST_HASH: cmd.hash_fold = 1'b1;
      ST_READ: cmd.mem_read = 1'b1;
      ST_CMP: begin
        if (stat.slot_free) begin
          if (stat.ids_exhausted) cmd.set_full = 1'b1;
          else cmd.do_insert = 1'b1;
        end else if (stat.key_match) begin
          cmd.set_hit = 1'b1;
        end else if (stat.probes_done) begin
          cmd.set_full = 1'b1;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      ST_EMIT: cmd.emit = 1'b1;
      default: ;
    endcase
  end
endmodule

FILE: src/kdi_datapath.sv
// Datapath of the k-mer dedup indexer: FASTA parser state, rolling k-mer
// register, split hash multiply, slot table memories. Depends on kdi_pkg.
module kdi_datapath (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] in_byte,
  input  logic cfg_we,
  input  logic [5:0] cfg_data,
  input  kdi_pkg::kdi_cmd_t cmd,
  output kdi_pkg::kdi_stat_t stat,
  output logic result_valid,
  output logic [63:0] kmer_code,
  output logic [15:0] kmer_id,
  output logic is_new,
  output logic table_full,
  output logic [31:0] read_index,
  output logic [31:0] kmer_pos
);
  import kdi_pkg::*;

  logic [5:0]  kmer_len;
  logic [63:0] kmer_shift;
  logic [5:0]  valid_run;
  logic        at_line_start, in_header, awaiting_record;
  logic [31:0] record_count, offset_in_record;
  logic [IdCntW-1:0] next_free_id;
  logic [SlotW:0] clr_cnt;

  logic        slot_used [TableEntries];
  logic [63:0] slot_key  [TableEntries];
  logic [15:0] slot_id   [TableEntries];

  logic [63:0] key;
  logic [31:0] pos;
  logic [63:0] prod;
  logic [31:0] pp_lo_hi, pp_hi_lo;
  logic [SlotW-1:0] probe_idx;
  logic [ProbeCntW-1:0] probe_cnt;
  logic        rd_used;
  logic [63:0] rd_key;
  logic [15:0] rd_id;

  // effective K
  logic [5:0] k_eff;
  always_comb begin
    if (kmer_len == 6'd0) k_eff = 6'd1;
    else if (kmer_len > 6'd32) k_eff = 6'd32;
    else k_eff = kmer_len;
  end

  // byte parse, combinational view of the step
  logic [7:0] ub;
  logic       is_base;
  logic [1:0] base;
  logic       seq_byte;
  logic [5:0] run_new;
  logic [63:0] shift_new;
  logic [63:0] mask;
  logic [31:0] off_cur;
  logic [31:0] rec_new;
  always_comb begin
    ub = (in_byte >= 8'h61 && in_byte <= 8'h7A) ? in_byte - 8'd32 : in_byte;
    is_base = 1'b1;
    base = 2'd0;
    case (ub)
      ChA: base = 2'd0;
      ChC: base = 2'd1;
      ChG: base = 2'd2;
      ChT: base = 2'd3;
      default: is_base = 1'b0;
    endcase
    seq_byte = !in_header && in_byte != ChNewline && !(at_line_start && in_byte == ChHeader);
    rec_new = record_count;
    if (awaiting_record && record_count != U32Max) rec_new = record_count + 32'd1;
    off_cur = awaiting_record ? 32'd0 : offset_in_record;
    shift_new = ((awaiting_record ? 64'd0 : kmer_shift) << 2) | {62'd0, base};
    run_new = awaiting_record ? 6'd0 : valid_run;
    if (run_new < 6'd32) run_new = run_new + 6'd1;
    mask = (k_eff >= 6'd32) ? '1 : ((64'd1 << {k_eff, 1'b0}) - 64'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= KmerLenReset;
      kmer_shift <= '0;
      valid_run <= '0;
      at_line_start <= 1'b1;
      in_header <= 1'b0;
      awaiting_record <= 1'b1;
      record_count <= '0;
      offset_in_record <= '0;
    end else begin
      if (cfg_we) kmer_len <= cfg_data;
      if (cmd.take_byte) begin
        if (in_header) begin
          if (in_byte == ChNewline) begin
            in_header <= 1'b0;
            at_line_start <= 1'b1;
          end
        end else if (in_byte == ChNewline) begin
          at_line_start <= 1'b1;
        end else if (at_line_start && in_byte == ChHeader) begin
          in_header <= 1'b1;
          at_line_start <= 1'b0;
          awaiting_record <= 1'b1;
        end else begin
          at_line_start <= 1'b0;
          awaiting_record <= 1'b0;
          record_count <= rec_new;
          offset_in_record <= (off_cur != U32Max) ? off_cur + 32'd1 : off_cur;
          if (is_base) begin
            kmer_shift <= shift_new;
            valid_run <= run_new;
          end else begin
            kmer_shift <= awaiting_record ? 64'd0 : kmer_shift;
            valid_run <= '0;
          end
        end
      end
    end
  end

  // lookup operands, latched when the byte is taken
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      key <= shift_new & mask;
      pos <= (off_cur == U32Max) ? U32Max : off_cur - 32'(k_eff - 6'd1);
      read_index <= rec_new - 32'd1;
    end
  end

  // 64x64 low product from 32x32 partial products, one per multiply state
  always_ff @(posedge clk) begin
    if (cmd.mul_step0) prod <= key[31:0] * HashMul[31:0];
    if (cmd.mul_step1) pp_lo_hi <= 32'(key[31:0] * HashMul[63:32]);
    if (cmd.mul_step2) pp_hi_lo <= 32'(key[63:32] * HashMul[31:0]);
  end

  logic [63:0] h;
  always_comb begin
    h = prod + {pp_lo_hi + pp_hi_lo, 32'd0};
    h = h ^ (h >> 29);
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_fold) begin
      probe_idx <= h[SlotW-1:0];
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      probe_idx <= probe_idx + SlotW'(1);
      probe_cnt <= probe_cnt + ProbeCntW'(1);
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.clear_slot) slot_used[clr_cnt[SlotW-1:0]] <= 1'b0;
    else if (cmd.do_insert) slot_used[probe_idx] <= 1'b1;
    if (cmd.mem_read) rd_used <= slot_used[probe_idx];
  end
  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      slot_key[probe_idx] <= key;
      slot_id[probe_idx] <= 16'(next_free_id);
    end
    if (cmd.mem_read) begin
      rd_key <= slot_key[probe_idx];
      rd_id <= slot_id[probe_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear_slot) clr_cnt <= clr_cnt + (SlotW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) next_free_id <= '0;
    else if (cmd.do_insert) next_free_id <= next_free_id + IdCntW'(1);
  end

  always_comb begin
    stat.clear_done = clr_cnt == (SlotW+1)'(TableEntries - 1);
    stat.want_lookup = seq_byte && is_base && run_new >= k_eff;
    stat.slot_free = !rd_used;
    stat.key_match = rd_used && rd_key == key;
    stat.ids_exhausted = next_free_id >= IdCntW'(IdLimit);
    stat.probes_done = probe_cnt == ProbeCntW'(TableEntries - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      kmer_id <= 16'(next_free_id);
      is_new <= 1'b1;
      table_full <= 1'b0;
    end else if (cmd.set_hit) begin
      kmer_id <= rd_id;
      is_new <= 1'b0;
      table_full <= 1'b0;
    end else if (cmd.set_full) begin
      kmer_id <= '0;
      is_new <= 1'b1;
      table_full <= 1'b1;
    end
  end

  assign result_valid = cmd.emit;
  assign kmer_code = key;
  assign kmer_pos = pos;
endmodule

FILE: src/kmer_dedup_indexer_top.sv
// Top level of the k-mer dedup indexer: controller plus datapath.
// Depends on kdi_pkg, kdi_ctrl, kdi_datapath.
//
//   channel  handshake        payload
//   input    start / busy     in_byte
//   config   kmer_len_we      kmer_len_data
//   result   result_valid     kmer_code kmer_id is_new table_full read_index kmer_pos
//
// A byte that yields no k-mer is taken without raising busy. A k-mer byte goes through accept,
// three partial multiplies, hash fold, a read/compare per probe
// of the single-ported slot table, then the result strobe; busy is high from the first multiply to the strobe.
// After reset a clearing pass over all 65536 slots holds busy high. The result strobe
// lasts one cycle; the receiver cannot stall.
module kmer_dedup_indexer_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [7:0] in_byte,
  input  logic kmer_len_we,
  input  logic [5:0] kmer_len_data,
  output logic result_valid,
  output logic [63:0] kmer_code,
  output logic [15:0] kmer_id,
  output logic is_new,
  output logic table_full,
  output logic [31:0] read_index,
  output logic [31:0] kmer_pos
);
  import kdi_pkg::*;

  kdi_cmd_t cmd;
  kdi_stat_t stat;

  kdi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  kdi_datapath u_dp (
    .clk(clk), .rst(rst), .in_byte(in_byte),
    .cfg_we(kmer_len_we), .cfg_data(kmer_len_data),
    .cmd(cmd), .stat(stat), .result_valid(result_valid),
    .kmer_code(kmer_code), .kmer_id(kmer_id), .is_new(is_new),
    .table_full(table_full), .read_index(read_index), .kmer_pos(kmer_pos)
  );
endmodule

FILE: dv/kmer_dedup_indexer_top_tb.sv
// Self-checking testbench for kmer_dedup_indexer_top: drives FASTA bytes and
// checks every k-mer result against directed expectations or an in-bench predictor of the hash table.
// Depends on kdi_pkg and the RTL of kmer_dedup_indexer_top.
module kmer_dedup_indexer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kdi_pkg::*;

  typedef struct packed {
    logic [63:0] code;
    logic [15:0] id;
    logic        fresh;
    logic        full;
    logic [31:0] rec;
    logic [31:0] pos;
  } kmer_res_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    kmer_res_t  res;
  } dir_row_t;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned NumRandom = 1430;
  localparam int unsigned CalmTail = 150;

  logic clk, rst, start, busy, kmer_len_we, result_valid;
  logic [7:0] in_byte;
  logic [5:0] kmer_len_data;
  logic [63:0] kmer_code;
  logic [15:0] kmer_id;
  logic is_new, table_full;
  logic [31:0] read_index, kmer_pos;

  kmer_dedup_indexer_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_byte(in_byte),
    .kmer_len_we(kmer_len_we), .kmer_len_data(kmer_len_data),
    .result_valid(result_valid), .kmer_code(kmer_code), .kmer_id(kmer_id),
    .is_new(is_new), .table_full(table_full), .read_index(read_index),
    .kmer_pos(kmer_pos)
  );

  // predictor state
  logic [5:0]  k_reg;
  logic [63:0] shift_reg;
  int unsigned run_len;
  bit          line_start, in_hdr, await_rec;
  logic [31:0] rec_cnt, rec_off;
  int unsigned free_id;
  bit          used_tab[TableEntries];
  logic [63:0] key_tab[TableEntries];
  logic [15:0] id_tab[TableEntries];

  kmer_res_t pending_kmers[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    kmer_res_t e;
    if (!rst && result_valid) begin
      if (pending_kmers.size() == 0) begin
        $error("unexpected k-mer beat code=%h", kmer_code);
        errors++;
      end else begin
        e = pending_kmers.pop_front();
        if (kmer_code !== e.code) begin
          $error("kmer_code exp %h got %h", e.code, kmer_code); errors++;
        end
        if (kmer_id !== e.id) begin
          $error("kmer_id exp %0d got %0d", e.id, kmer_id); errors++;
        end
        if (is_new !== e.fresh) begin
          $error("is_new exp %0b got %0b", e.fresh, is_new); errors++;
        end
        if (table_full !== e.full) begin
          $error("table_full exp %0b got %0b", e.full, table_full); errors++;
        end
        if (read_index !== e.rec) begin
          $error("read_index exp %0d got %0d", e.rec, read_index); errors++;
        end
        if (kmer_pos !== e.pos) begin
          $error("kmer_pos exp %0d got %0d", e.pos, kmer_pos); errors++;
        end
      end
    end
  end

  function automatic void reset_model();
    k_reg = KmerLenReset;
    shift_reg = '0;
    run_len = 0;
    line_start = 1;
    in_hdr = 0;
    await_rec = 1;
    rec_cnt = '0;
    rec_off = '0;
    free_id = 0;
    foreach (used_tab[i]) used_tab[i] = 0;
  endfunction

  // first-sight lookup with linear probing; inserts while ids remain
  function automatic void probe_table(input logic [63:0] key, inout kmer_res_t r);
    logic [63:0] h;
    int unsigned idx;
    h = key * HashMul;
    h = h ^ (h >> 29);
    idx = 32'(h % TableEntries);
    for (int unsigned n = 0; n < TableEntries; n++) begin
      if (!used_tab[idx]) begin
        if (free_id >= IdLimit) break;
        used_tab[idx] = 1;
        key_tab[idx] = key;
        id_tab[idx] = free_id[15:0];
        r.id = free_id[15:0];
        free_id++;
        r.fresh = 1; r.full = 0;
        return;
      end
      if (key_tab[idx] == key) begin
        r.id = id_tab[idx]; r.fresh = 0; r.full = 0;
        return;
      end
      idx = (idx + 1) % TableEntries;
    end
    r.id = '0; r.fresh = 1; r.full = 1;
  endfunction

  function automatic bit predict_kmer(input logic [7:0] b_in, output kmer_res_t r);
    logic [7:0] b;
    logic [1:0] base;
    logic [31:0] off;
    int unsigned k;
    b = b_in;
    r = '0;
    if (in_hdr) begin
      if (b == ChNewline) begin in_hdr = 0; line_start = 1; end
      return 0;
    end
    if (b == ChNewline) begin line_start = 1; return 0; end
    if (line_start && b == ChHeader) begin
      in_hdr = 1; line_start = 0; await_rec = 1;
      return 0;
    end
    line_start = 0;
    if (await_rec) begin
      await_rec = 0;
      if (rec_cnt != U32Max) rec_cnt++;
      rec_off = '0; run_len = 0; shift_reg = '0;
    end
    off = rec_off;
    if (rec_off != U32Max) rec_off++;
    if (b >= 8'h61 && b <= 8'h7A) b = b - 8'd32;
    case (b)
      ChA: base = 2'd0;
      ChC: base = 2'd1;
      ChG: base = 2'd2;
      ChT: base = 2'd3;
      default: begin run_len = 0; return 0; end
    endcase
    shift_reg = {shift_reg[61:0], base};
    if (run_len < 32) run_len++;
    k = (k_reg == 0) ? 1 : (k_reg > 32) ? 32 : 32'(k_reg);
    if (run_len < k) return 0;
    r.code = (k >= 32) ? shift_reg : shift_reg & ((64'd1 << (2 * k)) - 64'd1);
    probe_table(r.code, r);
    r.rec = rec_cnt - 32'd1;
    r.pos = (off == U32Max) ? U32Max : off - (k - 1);
    return 1;
  endfunction

  // drive one byte and hold it until accepted; returns at the accepting edge
  task automatic send_byte(input logic [7:0] b, input bit typed, input kmer_res_t tr);
    kmer_res_t r;
    bit hit;
    start <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (busy);
    hit = predict_kmer(b, r);
    if (typed) pending_kmers.push_back(tr);
    else if (hit) pending_kmers.push_back(r);
  endtask

  task automatic pause_sender(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_kmers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_k(input logic [5:0] v);
    drain();
    while (busy) @(posedge clk);
    kmer_len_we <= 1'b1;
    kmer_len_data <= v;
    @(posedge clk);
    k_reg = v;
    kmer_len_we <= 1'b0;
  endtask

  // mostly well-formed FASTA with random content, some noise
  function automatic logic [7:0] fasta_byte(ref bit hdr_open);
    int unsigned p;
    logic [7:0] acgt[8] = '{ChA, ChC, ChG, ChT, 8'h61, 8'h63, 8'h67, 8'h74};
    p = $urandom_range(99);
    if (hdr_open) begin
      if (p < 30) begin hdr_open = 0; return ChNewline; end
      return 8'($urandom_range(255));
    end
    if (p < 80) return acgt[(p < 60) ? $urandom_range(3) : $urandom_range(7)];
    if (p < 87) return ChNewline;
    if (p < 90) begin hdr_open = 1; return ChHeader; end
    return 8'($urandom_range(255));
  endfunction

  function automatic kmer_res_t mk(input logic [63:0] c, input logic [15:0] i,
                                   input logic f, input logic [31:0] rc,
                                   input logic [31:0] p);
    mk = '{code: c, id: i, fresh: f, full: 1'b0, rec: rc, pos: p};
  endfunction

  initial begin
    dir_row_t rows[$];
    kmer_res_t none;
    logic [5:0] ksets[8];
    bit hdr_open;
    int unsigned sent, n;

    ksets = '{6'd4, 6'd63, 6'd0, 6'd12, 6'd32, 6'd7, 6'd33, 6'd2};
    rst = 1; start = 0; in_byte = '0; kmer_len_we = 0; kmer_len_data = '0;
    none = '0;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at K=1: headers, case folding, non-ACGT, mid-line '>'
    rows = '{
      '{ChHeader, 0, none}, '{8'h68, 0, none}, '{ChNewline, 0, none},
      '{ChA, 1, mk(0, 0, 1, 0, 0)}, '{8'h63, 1, mk(1, 1, 1, 0, 1)},
      '{ChA, 1, mk(0, 0, 0, 0, 2)}, '{8'h4E, 0, none}, '{ChNewline, 0, none},
      '{ChT, 1, mk(3, 2, 1, 0, 4)}, '{ChHeader, 0, none},
      '{8'h67, 1, mk(2, 3, 1, 0, 6)}, '{ChNewline, 0, none}, '{ChNewline, 0, none},
      '{ChHeader, 0, none}, '{8'hFF, 0, none}, '{8'h00, 0, none},
      '{ChNewline, 0, none}, '{ChG, 1, mk(2, 3, 0, 1, 0)}, '{8'h7A, 0, none},
      '{8'h80, 0, none}, '{8'h74, 1, mk(3, 2, 0, 1, 3)}
    };
    write_k(6'd1);
    foreach (rows[i]) send_byte(rows[i].b, rows[i].typed, rows[i].res);

    // random part, one K setting per phase
    hdr_open = 0;
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_k(ksets[ph]);
      for (int j = 0; j < NumRandom / 8; j++) begin
        send_byte(fasta_byte(hdr_open), 0, none);
        sent++;
        if (ph == 3 && j == 60) drain();
        if (sent < NumRandom - CalmTail && $urandom_range(9) == 0) begin
          n = $urandom_range(1, 13);
          pause_sender(n);
        end
      end
    end
    write_k(KmerLenReset);
    for (int j = 0; j < 40; j++) send_byte(fasta_byte(hdr_open), 0, none);

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
